### rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants
// Item layouts, register indexes, body geometry and controller commands.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int BODY_LENGTH_MM  = 600;
   localparam int FRONT_OFFSET_MM = 100;
   localparam int HALF_WIDTH_MM   = 250;
   localparam int HORIZON_MM      = 1500;

   // body corners, forward / lateral, mm
   localparam logic signed [15:0] CX_FRONT = 16'(FRONT_OFFSET_MM);
   localparam logic signed [15:0] CX_REAR  = 16'(-(BODY_LENGTH_MM + FRONT_OFFSET_MM));
   localparam logic signed [15:0] CY_LEFT  = 16'(HALF_WIDTH_MM);
   localparam logic signed [15:0] CY_RIGHT = 16'(-HALF_WIDTH_MM);
   // longitudinal window
   localparam logic signed [16:0] X_LOW  = 17'(-(BODY_LENGTH_MM + FRONT_OFFSET_MM) - HORIZON_MM);
   localparam logic signed [16:0] X_HIGH = 17'(FRONT_OFFSET_MM + HORIZON_MM);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE       = 3'd0,
      REG_SW_TICKS   = 3'd1,
      REG_GAIN       = 3'd2,
      REG_TARGET     = 3'd3,
      REG_SMOOTHING  = 3'd4,
      REG_SPEED_LIM  = 3'd5,
      REG_FLANK_TOL  = 3'd6,
      REG_CTR_RANGE  = 3'd7
   } csr_index_type;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_SINGLE = 2'd2;

   localparam logic [1:0] RGM_NONE  = 2'd0;
   localparam logic [1:0] RGM_BOTH  = 2'd1;
   localparam logic [1:0] RGM_LEFT  = 2'd2;
   localparam logic [1:0] RGM_RIGHT = 2'd3;

   typedef struct packed {
      logic               has_wall;
      logic               end_of_scan;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [14:0]        line_offset;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] lateral_velocity;
      logic [1:0]         regime;
      logic               steer_active;
      logic [15:0]        left_clearance;
      logic [15:0]        right_clearance;
      logic               left_seen;
      logic               right_seen;
      logic [7:0]         flanking_count;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic wall_mul;
      logic wall_sum;
      logic wall_upd;
      logic eos_regime;
      logic law_mul;
      logic law_mix;
      logic law_fin;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic has_wall;
      logic end_of_scan;
      logic out_free;
   } sts_type;

endpackage

### rtl/lcc_ctrl.sv
// ----------------------------------------------------------------------------
// lcc_ctrl: sequencing state machine
// Steps one item through the wall checks and, at end of scan, the law.
// ----------------------------------------------------------------------------
module lcc_ctrl import lcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_WMUL = 9'b000000010,
      ST_WSUM = 9'b000000100,
      ST_WUPD = 9'b000001000,
      ST_EREG = 9'b000010000,
      ST_LMUL = 9'b000100000,
      ST_LMIX = 9'b001000000,
      ST_LFIN = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WMUL;
            end
         end
         ST_WMUL: begin
            // an item without a wall only closes the scan, or nothing
            if (sts.has_wall) begin
               cmd.wall_mul = 1'b1;
               state_in     = ST_WSUM;
            end else if (sts.end_of_scan) begin
               state_in = ST_EREG;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WSUM: begin
            cmd.wall_sum = 1'b1;
            state_in     = ST_WUPD;
         end
         ST_WUPD: begin
            cmd.wall_upd = 1'b1;
            state_in     = sts.end_of_scan ? ST_EREG : ST_IDLE;
         end
         ST_EREG: begin
            cmd.eos_regime = 1'b1;
            state_in       = ST_LMUL;
         end
         ST_LMUL: begin
            cmd.law_mul = 1'b1;
            state_in    = ST_LMIX;
         end
         ST_LMIX: begin
            cmd.law_mix = 1'b1;
            state_in    = ST_LFIN;
         end
         ST_LFIN: begin
            cmd.law_fin = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/lcc_dp.sv
// ----------------------------------------------------------------------------
// lcc_dp: centering datapath
// Wall classification, per-scan aggregates, regime hysteresis and the law.
// ----------------------------------------------------------------------------
module lcc_dp import lcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_item_type         req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data
);

   // configuration
   logic [1:0]  mode_ff;
   logic [7:0]  sw_ticks_ff;
   logic [15:0] gain_ff;
   logic [14:0] target_ff;
   logic [16:0] smooth_ff;
   logic [14:0] limit_ff;
   logic [16:0] tol_ff;
   logic [15:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 2'd1;
         sw_ticks_ff <= 8'd3;
         gain_ff     <= 16'd256;
         target_ff   <= 15'd300;
         smooth_ff   <= 17'd32768;
         limit_ff    <= 15'd300;
         tol_ff      <= 17'd58982;
         range_ff    <= 16'd1500;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_MODE:      mode_ff     <= csr_data[1:0];
            REG_SW_TICKS:  sw_ticks_ff <= csr_data[7:0];
            REG_GAIN:      gain_ff     <= csr_data[15:0];
            REG_TARGET:    target_ff   <= csr_data[14:0];
            REG_SMOOTHING: smooth_ff   <= csr_data;
            REG_SPEED_LIM: limit_ff    <= csr_data[14:0];
            REG_FLANK_TOL: tol_ff      <= csr_data;
            REG_CTR_RANGE: range_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // captured item
   req_item_type item_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
   end

   // ---- wall, first step: squares and corner line values
   logic signed [16:0] dx, dy, smin, smax;
   logic signed [33:0] corner_d [4];
   logic signed [15:0] cx_tab [4];
   logic signed [15:0] cy_tab [4];
   logic [31:0]        dx2_ff, dy2_ff;
   logic [33:0]        tol2_ff;
   logic               degen_ff, out_x_ff;
   logic signed [33:0] corner_ff [4];

   assign cx_tab = '{CX_FRONT, CX_REAR, CX_REAR, CX_FRONT};
   assign cy_tab = '{CY_LEFT, CY_LEFT, CY_RIGHT, CY_RIGHT};

   always_comb begin
      dx   = 17'(item_ff.end_x) - 17'(item_ff.start_x);
      dy   = 17'(item_ff.end_y) - 17'(item_ff.start_y);
      smin = (item_ff.start_x < item_ff.end_x) ? 17'(item_ff.start_x) : 17'(item_ff.end_x);
      smax = (item_ff.start_x < item_ff.end_x) ? 17'(item_ff.end_x) : 17'(item_ff.start_x);
      for (int i = 0; i < 4; i++) begin
         corner_d[i] = 34'(item_ff.normal_x * cx_tab[i])
                     + 34'(item_ff.normal_y * cy_tab[i])
                     + 34'($signed({1'b0, item_ff.line_offset, 14'd0}));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wall_mul) begin
         dx2_ff   <= 32'(dx * dx);
         dy2_ff   <= 32'(dy * dy);
         tol2_ff  <= 34'(tol_ff) * 34'(tol_ff);
         degen_ff <= (dx == 17'sd0) && (dy == 17'sd0);
         out_x_ff <= (smax < X_LOW) || (smin > X_HIGH);
         for (int i = 0; i < 4; i++) corner_ff[i] <= corner_d[i];
      end
   end

   // ---- wall, second step: tolerance product halves and nearest corner
   logic [32:0] len2;
   logic [32:0] corner_abs [4];
   logic [32:0] near01, near23, near;
   logic [49:0] prod_hi_ff, prod_lo_ff;
   logic [32:0] best_ff;

   always_comb begin
      len2 = 33'(dx2_ff) + 33'(dy2_ff);
      for (int i = 0; i < 4; i++) begin
         corner_abs[i] = corner_ff[i][33] ? 33'(-corner_ff[i]) : corner_ff[i][32:0];
      end
      near01 = (corner_abs[1] < corner_abs[0]) ? corner_abs[1] : corner_abs[0];
      near23 = (corner_abs[3] < corner_abs[2]) ? corner_abs[3] : corner_abs[2];
      near   = (near23 < near01) ? near23 : near01;
   end

   always_ff @(posedge clock) begin
      if (cmd.wall_sum) begin
         prod_hi_ff <= 50'(tol2_ff[33:17]) * 50'(len2);
         prod_lo_ff <= 50'(tol2_ff[16:0]) * 50'(len2);
         best_ff    <= near;
      end
   end

   // ---- wall, third step: decision and side update
   logic [66:0] rhs, lhs;
   logic [17:0] mm_full;
   logic [15:0] mm;
   logic        take, is_left;

   logic [15:0] left_best_ff, right_best_ff;
   logic        left_found_ff, right_found_ff;
   logic [7:0]  tally_ff;

   always_comb begin
      rhs     = {prod_hi_ff, 17'd0} + 67'(prod_lo_ff);
      lhs     = {3'd0, dx2_ff, 32'd0};
      mm_full = 18'((34'(best_ff) + 34'd8192) >> 14);
      mm      = (mm_full > 18'd65535) ? 16'hFFFF : mm_full[15:0];
      take    = !degen_ff && !(lhs < rhs) && !out_x_ff
              && (best_ff <= {3'd0, range_ff, 14'd0});
      is_left = (item_ff.line_offset != 15'd0) && item_ff.normal_y[15];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.law_fin) begin
         left_best_ff   <= 16'hFFFF;
         right_best_ff  <= 16'hFFFF;
         left_found_ff  <= 1'b0;
         right_found_ff <= 1'b0;
         tally_ff       <= 8'd0;
      end else if (cmd.wall_upd && take) begin
         if (tally_ff != 8'hFF) tally_ff <= tally_ff + 8'd1;
         if (is_left) begin
            if (!left_found_ff || mm < left_best_ff) begin
               left_best_ff  <= mm;
               left_found_ff <= 1'b1;
            end
         end else begin
            if (!right_found_ff || mm < right_best_ff) begin
               right_best_ff  <= mm;
               right_found_ff <= 1'b1;
            end
         end
      end
   end

   // ---- end of scan: regime hysteresis and error
   logic [1:0]  active_ff, pending_ff, cand, act_new;
   logic [7:0]  ticks_ff, ticks_up;
   logic signed [16:0] err_ff, err_in;
   logic        need_both;

   always_comb begin
      need_both = (mode_ff != MODE_SINGLE);
      if (left_found_ff && right_found_ff)  cand = RGM_BOTH;
      else if (!need_both && left_found_ff)  cand = RGM_LEFT;
      else if (!need_both && right_found_ff) cand = RGM_RIGHT;
      else                                   cand = RGM_NONE;

      if (cand == pending_ff) ticks_up = (ticks_ff == 8'hFF) ? ticks_ff : ticks_ff + 8'd1;
      else                    ticks_up = 8'd1;

      act_new = active_ff;
      if (cand != active_ff && ticks_up >= sw_ticks_ff) act_new = cand;

      err_in = 17'sd0;
      case (act_new)
         RGM_BOTH: begin
            if (left_found_ff && right_found_ff)
               err_in = 17'({1'b0, left_best_ff}) - 17'({1'b0, right_best_ff});
            else if (left_found_ff)
               err_in = 17'({1'b0, left_best_ff}) - 17'({2'b0, target_ff});
            else if (right_found_ff)
               err_in = 17'({2'b0, target_ff}) - 17'({1'b0, right_best_ff});
         end
         RGM_LEFT: begin
            if (left_found_ff)
               err_in = 17'({1'b0, left_best_ff}) - 17'({2'b0, target_ff});
         end
         RGM_RIGHT: begin
            if (right_found_ff)
               err_in = 17'({2'b0, target_ff}) - 17'({1'b0, right_best_ff});
         end
         default: err_in = 17'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= RGM_NONE;
         pending_ff <= RGM_NONE;
         ticks_ff   <= 8'd0;
      end else if (cmd.eos_regime && mode_ff != MODE_OFF) begin
         pending_ff <= cand;
         active_ff  <= act_new;
         if (cand == active_ff || ticks_up >= sw_ticks_ff) ticks_ff <= 8'd0;
         else                                              ticks_ff <= ticks_up;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eos_regime) err_ff <= err_in;
   end

   // ---- law: gain, blend with history, round, clamp
   logic signed [33:0] raw_ff;
   logic signed [51:0] mix_ff;
   logic [16:0]        w;
   logic signed [15:0] prev_ff;
   logic               hist_ff;

   always_comb begin
      w = (smooth_ff > 17'd65536) ? 17'd65536 : smooth_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.law_mul) raw_ff <= 34'($signed({1'b0, gain_ff})) * 34'(err_ff);
      if (cmd.law_mix) begin
         mix_ff <= 52'($signed({1'b0, w})) * 52'(raw_ff)
                 + (52'($signed({1'b0, 17'd65536 - w})) * 52'(prev_ff) <<< 8);
      end
   end

   logic [51:0]        mag;
   logic [27:0]        rnd;
   logic               neg;
   logic [27:0]        lim_mag;
   logic signed [15:0] vel;

   always_comb begin
      if (hist_ff) begin
         neg = mix_ff[51];
         mag = neg ? 52'(-mix_ff) : 52'(mix_ff);
         rnd = 28'((mag + 52'(1 << 23)) >> 24);
      end else begin
         neg = raw_ff[33];
         mag = neg ? 52'(-raw_ff) : 52'(raw_ff);
         rnd = 28'((mag + 52'd128) >> 8);
      end
      lim_mag = (rnd > 28'(limit_ff)) ? 28'(limit_ff) : rnd;
      vel     = neg ? -16'(lim_mag) : 16'(lim_mag);
   end

   rsp_item_type result_ff, result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 16'sd0;
         hist_ff <= 1'b0;
      end else if (cmd.law_fin && mode_ff != MODE_OFF) begin
         if (active_ff == RGM_NONE) begin
            prev_ff <= 16'sd0;
            hist_ff <= 1'b0;
         end else begin
            prev_ff <= vel;
            hist_ff <= 1'b1;
         end
      end
   end

   // disabled mode gives an all-zero item
   always_comb begin
      result_in = '0;
      if (mode_ff != MODE_OFF) begin
         result_in.regime          = active_ff;
         result_in.left_clearance  = left_found_ff ? left_best_ff : 16'd0;
         result_in.right_clearance = right_found_ff ? right_best_ff : 16'd0;
         result_in.left_seen       = left_found_ff;
         result_in.right_seen      = right_found_ff;
         result_in.flanking_count  = tally_ff;
         if (active_ff != RGM_NONE) begin
            result_in.lateral_velocity = vel;
            result_in.steer_active     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.law_fin) result_ff <= result_in;
   end

   // ---- output register
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= result_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign sts.has_wall    = item_ff.has_wall;
   assign sts.end_of_scan = item_ff.end_of_scan;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/lateral_centering_controller_top.sv
// ----------------------------------------------------------------------------
// lateral_centering_controller_top: wall-following lateral centering
// Classifies the wall segments of a scan and, at end of scan, issues a
// filtered, clamped lateral velocity command with regime hysteresis.
// ----------------------------------------------------------------------------
//  port group | direction | handshake         | carries
//  req_*      | in        | valid / stall     | one wall segment item
//  rsp_*      | out       | valid / stall     | one result item per scan
//  csr_*      | in        | valid / ready     | register index and data
//
//  An item is taken only when the sequencer is idle. A wall item passes
//  through capture, squares, tolerance products and decision; an item
//  without a wall or end of scan passes only through capture and the
//  wall check. End of scan adds regime, gain, blend, round, output load.
//  Reset is synchronous and restores the register defaults and empty scan.
//  The output register holds a result while rsp_stall is high; a closing
//  item waits in its last step only if the previous result is still held.
//  csr_ready is always high; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module lateral_centering_controller_top import lcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // wall segment items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer: one step per cycle, but the output step waits while the previous result is still held
   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, scan state, regime state and output register
   lcc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
